// ===== rtl/p25_pkg.sv =====
// shared types, constants and limb helpers for the p25519 field unit
package p25_pkg;

  typedef logic [63:0] limb_t;
  typedef limb_t [4:0] limbs_t;

  // operation codes
  localparam logic [2:0] KIND_ADD   = 3'd0;
  localparam logic [2:0] KIND_SUB   = 3'd1;
  localparam logic [2:0] KIND_MUL   = 3'd2;
  localparam logic [2:0] KIND_SQ    = 3'd3;
  localparam logic [2:0] KIND_DSQ   = 3'd4;
  localparam logic [2:0] KIND_CANON = 3'd5;

  localparam limb_t LIMB_MASK = 64'h0007_FFFF_FFFF_FFFF;
  localparam limb_t BIAS0     = 64'h003F_FFFF_FFFF_FF68;
  localparam limb_t BIASN     = 64'h003F_FFFF_FFFF_FFF8;
  localparam limb_t OFF0      = 64'h0007_FFFF_FFFF_FFED;
  localparam limb_t OFFN      = 64'h0007_FFFF_FFFF_FFFF;
  localparam limb_t FOLD      = 64'd19;

  typedef struct packed {
    limbs_t t;
    limb_t  c;
  } ripple_t;

  // times 19, wrapping at 64 bits
  function automatic limb_t mul19(input limb_t x);
    return (x << 4) + (x << 1) + x;
  endfunction

  // one carry pass over five limbs, carry out of limb 4 returned
  function automatic ripple_t ripple(input limbs_t t);
    ripple_t r;
    limb_t   c;
    limb_t   s;
    c = '0;
    for (int i = 0; i < 5; i++) begin
      s      = t[i] + c;
      c      = {51'd0, s[63:51]};
      r.t[i] = s & LIMB_MASK;
    end
    r.c = c;
    return r;
  endfunction

endpackage

// ===== rtl/p25_req_if.sv =====
// request channel: operation code and two five-limb operands
interface p25_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [63:0] a_limb0;
  logic [63:0] a_limb1;
  logic [63:0] a_limb2;
  logic [63:0] a_limb3;
  logic [63:0] a_limb4;
  logic [63:0] b_limb0;
  logic [63:0] b_limb1;
  logic [63:0] b_limb2;
  logic [63:0] b_limb3;
  logic [63:0] b_limb4;
  modport source (output valid, kind, a_limb0, a_limb1, a_limb2, a_limb3, a_limb4,
                  b_limb0, b_limb1, b_limb2, b_limb3, b_limb4, input ready);
  modport sink (input valid, kind, a_limb0, a_limb1, a_limb2, a_limb3, a_limb4,
                b_limb0, b_limb1, b_limb2, b_limb3, b_limb4, output ready);
endinterface

// ===== rtl/p25_rsp_if.sv =====
// result channel: five result limbs
interface p25_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] res_limb0;
  logic [63:0] res_limb1;
  logic [63:0] res_limb2;
  logic [63:0] res_limb3;
  logic [63:0] res_limb4;
  modport source (output valid, res_limb0, res_limb1, res_limb2, res_limb3, res_limb4,
                  input ready);
  modport sink (input valid, res_limb0, res_limb1, res_limb2, res_limb3, res_limb4,
                output ready);
endinterface

// ===== rtl/p25519_field_alu_unit.sv =====
// Field unit for 2^255-19 on five 51-bit limbs. One item enters per cycle unless the pipe
// is stalled; each result passes operand prep, partial products, product recombine,
// column sums, carry chain and final fold into the output register. All 25 limb products
// run in parallel on dedicated 64x64 multipliers split into 32x32 parts; canonical reduce
// runs its carry passes alongside in the same stages. Filled stages stall behind the output
// register when the result side is not ready, while empty stages still take new data.
module p25519_field_alu_unit
  import p25_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  p25_req_if.sink   req,
  p25_rsp_if.source rsp
);

  typedef logic [4:0][4:0][63:0] pairs_t;

  logic [6:1] v;
  logic [7:1] en;

  // stage registers
  logic [2:0]  kind1, kind2, kind3, kind4, kind5, kind6;
  limbs_t      side1, side2, side3, side4, side5;
  pairs_t      x1, y1;
  logic [4:0][4:0][127:0] prod;
  logic [4:0][127:0] col4;
  limbs_t      r5;
  limb_t       c5;
  limbs_t      res6;

  // stall chain
  always_comb begin
    en[7] = rsp.ready;
    for (int k = 6; k >= 1; k--) begin
      en[k] = !v[k] || en[k + 1];
    end
  end

  assign req.ready = en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) v[1] <= req.valid;
      for (int k = 2; k <= 6; k++) begin
        if (en[k]) v[k] <= v[k - 1];
      end
    end
  end

  // stage 1: operand prep, lazy add and subtract, first reduce pass
  limbs_t  a, b;
  pairs_t  xs, ys;
  limbs_t  side_s1;
  ripple_t rp1;
  limb_t   b1f, b2f, b3f, b4f, d0, d1, d2, e4, d4, a3f;

  always_comb begin
    a = {req.a_limb4, req.a_limb3, req.a_limb2, req.a_limb1, req.a_limb0};
    b = {req.b_limb4, req.b_limb3, req.b_limb2, req.b_limb1, req.b_limb0};
    b1f = mul19(b[1]);
    b2f = mul19(b[2]);
    b3f = mul19(b[3]);
    b4f = mul19(b[4]);
    d0  = a[0] << 1;
    d1  = a[1] << 1;
    d2  = mul19(a[2]) << 1;
    e4  = mul19(a[4]);
    d4  = e4 << 1;
    a3f = mul19(a[3]);
    xs  = '0;
    ys  = '0;
    side_s1 = '0;
    rp1 = ripple(a);
    case (req.kind)
      KIND_MUL: begin
        xs[0] = {b3f, b2f, b1f, b4f, b[0]}; ys[0] = {a[2], a[3], a[4], a[1], a[0]};
        xs[1] = {b3f, b2f, b4f, b[1], b[0]}; ys[1] = {a[3], a[4], a[2], a[0], a[1]};
        xs[2] = {b3f, b4f, b[1], b[2], b[0]}; ys[2] = {a[4], a[3], a[1], a[0], a[2]};
        xs[3] = {b4f, b[2], b[1], b[3], b[0]}; ys[3] = {a[4], a[1], a[2], a[0], a[3]};
        xs[4] = {b[2], b[1], b[3], b[4], b[0]}; ys[4] = {a[2], a[3], a[1], a[0], a[4]};
      end
      KIND_SQ, KIND_DSQ: begin
        xs[0] = {64'd0, 64'd0, d2, d4, a[0]};   ys[0] = {64'd0, 64'd0, a[3], a[1], a[0]};
        xs[1] = {64'd0, 64'd0, a[3], d4, d0};   ys[1] = {64'd0, 64'd0, a3f, a[2], a[1]};
        xs[2] = {64'd0, 64'd0, d4, a[1], d0};   ys[2] = {64'd0, 64'd0, a[3], a[1], a[2]};
        xs[3] = {64'd0, 64'd0, a[4], d1, d0};   ys[3] = {64'd0, 64'd0, e4, a[2], a[3]};
        xs[4] = {64'd0, 64'd0, a[2], d1, d0};   ys[4] = {64'd0, 64'd0, a[2], a[3], a[4]};
      end
      KIND_ADD: begin
        for (int i = 0; i < 5; i++) side_s1[i] = a[i] + b[i];
      end
      KIND_SUB: begin
        side_s1[0] = (a[0] + BIAS0) - b[0];
        for (int i = 1; i < 5; i++) side_s1[i] = (a[i] + BIASN) - b[i];
      end
      KIND_CANON: begin
        side_s1    = rp1.t;
        side_s1[0] = rp1.t[0] + mul19(rp1.c);
      end
      default: begin
        side_s1 = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      kind1 <= req.kind;
      x1    <= xs;
      y1    <= ys;
      side1 <= side_s1;
    end
  end

  // stages 2 and 3: limb products
  for (genvar c = 0; c < 5; c++) begin : g_col
    for (genvar j = 0; j < 5; j++) begin : g_term
      p25_mul64 u_mul (
        .clk    (clk),
        .en_pp  (en[2]),
        .en_sum (en[3]),
        .x      (x1[c][j]),
        .y      (y1[c][j]),
        .p      (prod[c][j])
      );
    end
  end

  // reduce passes riding along stages 2 to 4
  ripple_t rp2, rp3, rp4;
  limbs_t  t3, t4, side_s2, side_s3, side_s4;

  always_comb begin
    rp2     = ripple(side1);
    side_s2 = side1;
    if (kind1 == KIND_CANON) begin
      side_s2    = rp2.t;
      side_s2[0] = rp2.t[0] + mul19(rp2.c);
    end
    t3      = side2;
    t3[0]   = side2[0] + FOLD;
    rp3     = ripple(t3);
    side_s3 = (kind2 == KIND_CANON) ? rp3.t : side2;
    t4[0]   = side3[0] + OFF0;
    for (int i = 1; i < 5; i++) t4[i] = side3[i] + OFFN;
    rp4     = ripple(t4);
    side_s4 = (kind3 == KIND_CANON) ? rp4.t : side3;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      kind2 <= kind1;
      side2 <= side_s2;
    end
    if (en[3]) begin
      kind3 <= kind2;
      side3 <= side_s3;
    end
  end

  // stage 4: column sums, doubled for the doubled square
  logic [4:0][127:0] col_s;

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      col_s[i] = prod[i][0] + prod[i][1] + prod[i][2] + prod[i][3] + prod[i][4];
      if (kind3 == KIND_DSQ) col_s[i] = col_s[i] << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      kind4 <= kind3;
      side4 <= side_s4;
      col4  <= col_s;
    end
  end

  // stage 5: carry chain through the columns
  logic [127:0] cv;
  limb_t        cc;
  limbs_t       r_s;

  always_comb begin
    cc = '0;
    for (int i = 0; i < 5; i++) begin
      cv     = col4[i] + {64'd0, cc};
      r_s[i] = {13'd0, cv[50:0]};
      cc     = cv[114:51];
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      kind5 <= kind4;
      side5 <= side4;
      r5    <= r_s;
      c5    <= cc;
    end
  end

  // stage 6: fold top carry into limb 0, pick the result
  limb_t  f0;
  limbs_t res_s;

  always_comb begin
    f0       = r5[0] + mul19(c5);
    res_s    = r5;
    res_s[0] = f0 & LIMB_MASK;
    res_s[1] = r5[1] + {51'd0, f0[63:51]};
    if (!(kind5 == KIND_MUL || kind5 == KIND_SQ || kind5 == KIND_DSQ)) res_s = side5;
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      kind6 <= kind5;
      res6  <= res_s;
    end
  end

  assign rsp.valid     = v[6];
  assign rsp.res_limb0 = res6[0];
  assign rsp.res_limb1 = res6[1];
  assign rsp.res_limb2 = res6[2];
  assign rsp.res_limb3 = res6[3];
  assign rsp.res_limb4 = res6[4];

`ifndef SYNTHESIS
  a_accept_enters : assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> v[1])
    else $error("accepted item did not enter the pipeline");
  a_stall_holds : assert property (@(posedge clk) disable iff (rst)
    v[6] && !rsp.ready |=> v[6] && $stable(res6))
    else $error("stalled result changed");
  a_unknown_zero : assert property (@(posedge clk) disable iff (rst)
    v[6] && (kind6 == 3'd6 || kind6 == 3'd7) |-> res6 == '0)
    else $error("unknown operation gave a non-zero result");
  a_canon_narrow : assert property (@(posedge clk) disable iff (rst)
    v[6] && kind6 == KIND_CANON |-> res6[4][63:51] == '0)
    else $error("canonical result limb 4 exceeds 51 bits");
`endif

endmodule

// ===== rtl/p25_mul64.sv =====
// two-stage 64 by 64 multiplier built from four 32 by 32 partial products
module p25_mul64 (
  input  logic         clk,
  input  logic         en_pp,
  input  logic         en_sum,
  input  logic [63:0]  x,
  input  logic [63:0]  y,
  output logic [127:0] p
);

  logic [63:0] pp00, pp01, pp10, pp11;

  // partial products
  always_ff @(posedge clk) begin
    if (en_pp) begin
      pp00 <= 64'(x[31:0])  * 64'(y[31:0]);
      pp01 <= 64'(x[31:0])  * 64'(y[63:32]);
      pp10 <= 64'(x[63:32]) * 64'(y[31:0]);
      pp11 <= 64'(x[63:32]) * 64'(y[63:32]);
    end
  end

  // recombine
  always_ff @(posedge clk) begin
    if (en_sum) begin
      p <= {64'd0, pp00} + ({64'd0, pp01} << 32) + ({64'd0, pp10} << 32)
         + {pp11, 64'd0};
    end
  end

endmodule

// ===== verif/p25519_field_alu_unit_tb.sv =====
// self-checking testbench for the p25519 field unit: directed table then random items
`timescale 1ns / 1ps

module p25519_field_alu_unit_tb;
  import p25_pkg::*;

  localparam int N_RANDOM   = 900;
  localparam int CYCLE_CAP  = 200000;
  localparam int DRAIN_WAIT = 20;

  typedef logic [127:0] col_t;

  typedef struct {
    logic [2:0] kind;
    limbs_t     a;
    limbs_t     b;
    logic       known;
    limbs_t     res;
  } op_row_t;

  logic clk;
  logic rst;
  int   cycle_cnt;
  int   fail_cnt;
  bit   no_idle;

  p25_req_if req ();
  p25_rsp_if rsp ();

  limbs_t  pending_res[$];
  op_row_t op_table[$];

  p25519_field_alu_unit u_top (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .rsp(rsp.source)
  );

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // carry chain over 128-bit column sums with fold of the top carry
  function automatic limbs_t settle_cols(input col_t t[5]);
    limbs_t r;
    limb_t  c;
    col_t   v;
    c = '0;
    for (int i = 0; i < 5; i++) begin
      v    = t[i] + col_t'(c);
      r[i] = v[63:0] & LIMB_MASK;
      c    = v[114:51];
    end
    r[0] = r[0] + c * FOLD;
    c    = r[0] >> 51;
    r[0] = r[0] & LIMB_MASK;
    r[1] = r[1] + c;
    return r;
  endfunction

  function automatic col_t wprod(input limb_t x, input limb_t y);
    return col_t'(x) * col_t'(y);
  endfunction

  function automatic limbs_t field_product(input limbs_t a, input limbs_t b);
    col_t  t[5];
    limb_t f1, f2, f3, f4;
    f1 = b[1] * FOLD;
    f2 = b[2] * FOLD;
    f3 = b[3] * FOLD;
    f4 = b[4] * FOLD;
    t[0] = wprod(b[0], a[0]) + wprod(f4, a[1]) + wprod(f1, a[4]) + wprod(f2, a[3])
         + wprod(f3, a[2]);
    t[1] = wprod(b[0], a[1]) + wprod(b[1], a[0]) + wprod(f4, a[2]) + wprod(f2, a[4])
         + wprod(f3, a[3]);
    t[2] = wprod(b[0], a[2]) + wprod(b[2], a[0]) + wprod(b[1], a[1]) + wprod(f4, a[3])
         + wprod(f3, a[4]);
    t[3] = wprod(b[0], a[3]) + wprod(b[3], a[0]) + wprod(b[1], a[2]) + wprod(b[2], a[1])
         + wprod(f4, a[4]);
    t[4] = wprod(b[0], a[4]) + wprod(b[4], a[0]) + wprod(b[3], a[1]) + wprod(b[1], a[3])
         + wprod(b[2], a[2]);
    return settle_cols(t);
  endfunction

  function automatic limbs_t field_square(input limbs_t a, input bit twice);
    col_t  t[5];
    limb_t d0, d1, d2, e4, d4;
    d0 = a[0] * 2;
    d1 = a[1] * 2;
    d2 = a[2] * 2 * FOLD;
    e4 = a[4] * FOLD;
    d4 = e4 * 2;
    t[0] = wprod(a[0], a[0]) + wprod(d4, a[1]) + wprod(d2, a[3]);
    t[1] = wprod(d0, a[1]) + wprod(d4, a[2]) + wprod(a[3], a[3] * FOLD);
    t[2] = wprod(d0, a[2]) + wprod(a[1], a[1]) + wprod(d4, a[3]);
    t[3] = wprod(d0, a[3]) + wprod(d1, a[2]) + wprod(a[4], e4);
    t[4] = wprod(d0, a[4]) + wprod(d1, a[3]) + wprod(a[2], a[2]);
    if (twice)
      for (int i = 0; i < 5; i++) t[i] = t[i] << 1;
    return settle_cols(t);
  endfunction

  // one carry pass, returns carry out of limb 4
  function automatic limb_t carry_pass(inout limbs_t t);
    limb_t c;
    c = '0;
    for (int i = 0; i < 5; i++) begin
      t[i] = t[i] + c;
      c    = t[i] >> 51;
      t[i] = t[i] & LIMB_MASK;
    end
    return c;
  endfunction

  function automatic limbs_t canonical(input limbs_t a);
    limbs_t t;
    limb_t  c;
    t = a;
    c = carry_pass(t);
    t[0] = t[0] + c * FOLD;
    c = carry_pass(t);
    t[0] = t[0] + c * FOLD;
    t[0] = t[0] + FOLD;
    c = carry_pass(t);
    t[0] = t[0] + OFF0;
    for (int i = 1; i < 5; i++) t[i] = t[i] + OFFN;
    c = carry_pass(t);
    return t;
  endfunction

  function automatic limbs_t alu_result(input logic [2:0] kind, input limbs_t a,
                                        input limbs_t b);
    limbs_t r;
    r = '0;
    case (kind)
      KIND_ADD: begin
        for (int i = 0; i < 5; i++) r[i] = a[i] + b[i];
      end
      KIND_SUB: begin
        r[0] = a[0] + BIAS0 - b[0];
        for (int i = 1; i < 5; i++) r[i] = a[i] + BIASN - b[i];
      end
      KIND_MUL:   r = field_product(a, b);
      KIND_SQ:    r = field_square(a, 1'b0);
      KIND_DSQ:   r = field_square(a, 1'b1);
      KIND_CANON: r = canonical(a);
      default:    r = '0;
    endcase
    return r;
  endfunction

  function automatic limb_t rand_limb();
    limb_t v;
    case ($urandom_range(0, 5))
      0: v = {$urandom, $urandom};
      1: v = {$urandom, $urandom} & LIMB_MASK;
      2: v = {$urandom, $urandom} & 64'h000F_FFFF_FFFF_FFFF;
      3: v = '1;
      4: v = LIMB_MASK - 64'($urandom_range(0, 20));
      default: v = 64'($urandom_range(0, 40));
    endcase
    return v;
  endfunction

  task automatic add_row(input logic [2:0] kind, input limbs_t a, input limbs_t b,
                         input logic known, input limbs_t res);
    op_row_t row;
    row.kind  = kind;
    row.a     = a;
    row.b     = b;
    row.known = known;
    row.res   = res;
    op_table.push_back(row);
  endtask

  // valid stays high between back-to-back items, drops only for an idle burst
  task automatic send_item(input logic [2:0] kind, input limbs_t a, input limbs_t b);
    if (!no_idle && $urandom_range(0, 7) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    req.valid   <= 1'b1;
    req.kind    <= kind;
    req.a_limb0 <= a[0];
    req.a_limb1 <= a[1];
    req.a_limb2 <= a[2];
    req.a_limb3 <= a[3];
    req.a_limb4 <= a[4];
    req.b_limb0 <= b[0];
    req.b_limb1 <= b[1];
    req.b_limb2 <= b[2];
    req.b_limb3 <= b[3];
    req.b_limb4 <= b[4];
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // result side ready, idle bursts
  initial begin
    rsp.ready = 1'b0;
    @(negedge clk);
    while (!rst) @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      rsp.ready <= 1'b1;
      @(negedge clk);
      if (!no_idle && $urandom_range(0, 7) == 0) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end
    end
  end

  // checker at rising edge
  always @(posedge clk) begin
    limbs_t got;
    limbs_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      got = {rsp.res_limb4, rsp.res_limb3, rsp.res_limb2, rsp.res_limb1, rsp.res_limb0};
      if (pending_res.size() == 0) begin
        $error("result item with nothing expected");
        fail_cnt++;
      end else begin
        want = pending_res.pop_front();
        for (int i = 0; i < 5; i++)
          if (got[i] !== want[i]) begin
            $error("res_limb%0d expected %h got %h", i, want[i], got[i]);
            fail_cnt++;
          end
      end
    end
  end

  // prediction at acceptance
  always @(posedge clk) begin
    limbs_t a;
    limbs_t b;
    if (!rst && req.valid && req.ready) begin
      a = {req.a_limb4, req.a_limb3, req.a_limb2, req.a_limb1, req.a_limb0};
      b = {req.b_limb4, req.b_limb3, req.b_limb2, req.b_limb1, req.b_limb0};
      pending_res.push_back(alu_result(req.kind, a, b));
    end
  end

  // cycle limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("p25519_field_alu_unit_tb: errors");
      $finish;
    end
  end

  initial begin
    limbs_t     z;
    limbs_t     ones;
    limbs_t     msk;
    limbs_t     pm;
    limbs_t     a;
    limbs_t     b;
    logic [2:0] kind;
    int         n;
    z         = '0;
    ones      = '1;
    msk       = {5{LIMB_MASK}};
    pm        = {LIMB_MASK, LIMB_MASK, LIMB_MASK, LIMB_MASK, OFF0};
    cycle_cnt = 0;
    fail_cnt  = 0;
    no_idle   = 1'b0;
    rst       = 1'b1;
    req.valid = 1'b0;
    req.kind  = '0;
    {req.a_limb0, req.a_limb1, req.a_limb2, req.a_limb3, req.a_limb4} = '0;
    {req.b_limb0, req.b_limb1, req.b_limb2, req.b_limb3, req.b_limb4} = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table: zeros, all ones, p itself, unknown codes, b ignored
    add_row(KIND_ADD, z, z, 1'b1, z);
    add_row(KIND_ADD, ones, ones, 1'b1, {5{64'hFFFF_FFFF_FFFF_FFFE}});
    add_row(KIND_SUB, z, z, 1'b1, {BIASN, BIASN, BIASN, BIASN, BIAS0});
    add_row(KIND_SUB, ones, ones, 1'b0, z);
    add_row(KIND_SUB, z, ones, 1'b0, z);
    add_row(KIND_MUL, z, ones, 1'b1, z);
    add_row(KIND_MUL, ones, ones, 1'b0, z);
    add_row(KIND_MUL, msk, msk, 1'b0, z);
    add_row(KIND_MUL, pm, msk, 1'b0, z);
    add_row(KIND_SQ, z, ones, 1'b1, z);
    add_row(KIND_SQ, ones, z, 1'b0, z);
    add_row(KIND_SQ, msk, ones, 1'b0, z);
    add_row(KIND_DSQ, ones, z, 1'b0, z);
    add_row(KIND_DSQ, msk, ones, 1'b0, z);
    add_row(KIND_CANON, z, ones, 1'b1, z);
    add_row(KIND_CANON, pm, z, 1'b1, pm);
    add_row(KIND_CANON, msk, z, 1'b1, msk);
    add_row(KIND_CANON, ones, z, 1'b0, z);
    add_row(3'd6, ones, ones, 1'b1, z);
    add_row(3'd7, ones, ones, 1'b1, z);
    foreach (op_table[i]) begin
      if (op_table[i].known &&
          alu_result(op_table[i].kind, op_table[i].a, op_table[i].b) !== op_table[i].res) begin
        $error("table row %0d: typed result disagrees with predictor", i);
        fail_cnt++;
      end
      send_item(op_table[i].kind, op_table[i].a, op_table[i].b);
    end

    // random items, last stretch without idling
    for (n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM - 100) no_idle = 1'b1;
      kind = ($urandom_range(0, 30) == 0) ? 3'($urandom_range(6, 7))
                                          : 3'($urandom_range(0, 5));
      for (int i = 0; i < 5; i++) begin
        a[i] = rand_limb();
        b[i] = rand_limb();
      end
      send_item(kind, a, b);
    end
    req.valid <= 1'b0;

    // drain
    while (pending_res.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_cnt == 0)
      $display("p25519_field_alu_unit_tb: clean");
    else
      $display("p25519_field_alu_unit_tb: errors");
    $finish;
  end

endmodule
